/* hdl/tgq_pkg.sv */
// ---------------------------------------------------------------------------
// tgq_pkg: shared types and constants of the tap gesture qualifier
// Gesture codes, register indexes, reset values and the configuration bundle.
// ---------------------------------------------------------------------------
package tgq_pkg;

   localparam int DEF_TIME_BITS = 32;
   localparam int DEF_DIR_BITS  = 8;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [7:0]  RATE_LIMIT_RESET  = 8'd5;
   localparam logic [15:0] DEBOUNCE_RESET    = 16'd200;
   localparam logic [15:0] WINDOW_RESET      = 16'd500;
   localparam logic [15:0] MIN_GAP_RESET     = 16'd50;
   localparam logic [7:0]  NEUTRAL_DIR_RESET = 8'd0;

   localparam logic [7:0] EVENT_COUNT_MAX = 8'd255;
   localparam logic [1:0] TAP_COUNT_MAX   = 2'd3;
   localparam logic [1:0] TAP_COUNT_ONE   = 2'd1;

   localparam logic REQ_EVENT = 1'b0;
   localparam logic REQ_TICK  = 1'b1;

   typedef enum logic [2:0] {
      GEST_NONE  = 3'd0,
      GEST_STAP  = 3'd1,
      GEST_DTAP  = 3'd2,
      GEST_SHAKE = 3'd3,
      GEST_SWIPE = 3'd4
   } gesture_type;

   typedef enum logic [2:0] {
      REG_RATE_LIMIT  = 3'd0,
      REG_DEBOUNCE_MS = 3'd1,
      REG_WINDOW_MS   = 3'd2,
      REG_MIN_GAP_MS  = 3'd3,
      REG_NEUTRAL_DIR = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  rate_limit;
      logic [15:0] debounce_ms;
      logic [15:0] window_ms;
      logic [15:0] min_gap_ms;
      logic [7:0]  neutral_dir;
   } cfg_type;

endpackage

/* hdl/tap_gesture_qualifier_unit.sv */
// ---------------------------------------------------------------------------
// tap_gesture_qualifier_unit: tap, double tap, shake and swipe qualifier
// Input register, single-pass decision logic and result register.
// ---------------------------------------------------------------------------
// The unit takes one word per clock cycle while req_stall is low: a gesture
// event or a periodic tick, each stamped with a wrapping millisecond time.
// Events go through a rate limiter (drained by ticks) and a debounce after the
// last recognized action; two taps more than the min gap apart and within the
// window become a double tap, a lone tap is reported as a single tap on the
// first tick after the window, and shake, swipe and double tap events pass
// straight through. Each word is captured in an input register, decided by
// compare/subtract logic and, when it yields an action, lands in the result
// register, where rsp_valid rises; a result waiting under rsp_stall can hold
// the word in the input register. The sustained rate is one word per cycle,
// set by the single decision stage between the two registers; the input stalls
// only while a result waits under rsp_stall. A word that yields no action still
// updates the state and leaves no result. Program the registers over the APB
// port only while no word is in flight.
// ---------------------------------------------------------------------------
module tap_gesture_qualifier_unit #(
   parameter int TIME_BITS = tgq_pkg::DEF_TIME_BITS,
   parameter int DIR_BITS  = tgq_pkg::DEF_DIR_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_type,
   input  logic [TIME_BITS-1:0]               req_now_ms,
   input  logic [2:0]                         req_gesture,
   input  logic [DIR_BITS-1:0]                req_dir_mask,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [2:0]                         rsp_action,
   output logic [DIR_BITS-1:0]                rsp_action_dir,
   output logic [TIME_BITS-1:0]               rsp_action_time,
   // configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [tgq_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [tgq_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [tgq_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   tgq_pkg::cfg_type cfg;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic                 in_type_ff;
   logic [TIME_BITS-1:0] in_now_ff;
   logic [2:0]           in_gesture_ff;
   logic [DIR_BITS-1:0]  in_dir_ff;

   // result register
   logic                 out_valid_ff, out_valid_in;
   logic [2:0]           out_action_ff;
   logic [DIR_BITS-1:0]  out_dir_ff;
   logic [TIME_BITS-1:0] out_time_ff;

   logic                 accept;
   logic                 advance;
   logic                 eng_hit;
   logic [2:0]           eng_action;
   logic [DIR_BITS-1:0]  eng_dir;

   tgq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tgq_engine #(
      .TIME_BITS (TIME_BITS),
      .DIR_BITS  (DIR_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .cfg        (cfg),
      .in_type    (in_type_ff),
      .in_now     (in_now_ff),
      .in_gesture (in_gesture_ff),
      .in_dir     (in_dir_ff),
      .out_hit    (eng_hit),
      .out_action (eng_action),
      .out_dir    (eng_dir)
   );

   // Advance the held word when the result register is free or being drained;
   // a word that yields no action advances under the same rule, which keeps
   // results in order.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      if (advance) begin
         out_valid_in = eng_hit;
      end else begin
         // hold a stalled result, drop one that was taken
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // capture payload of an accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         in_type_ff    <= req_type;
         in_now_ff     <= req_now_ms;
         in_gesture_ff <= req_gesture;
         in_dir_ff     <= req_dir_mask;
      end
   end

   // load the result register only when a recognized action leaves the engine
   always_ff @(posedge clock) begin
      if (advance && eng_hit) begin
         out_action_ff <= eng_action;
         out_dir_ff    <= eng_dir;
         out_time_ff   <= in_now_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_action      = out_action_ff;
   assign rsp_action_dir  = out_dir_ff;
   assign rsp_action_time = out_time_ff;

   // stall is raised only against a word already held
   a_stall_needs_word: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stall without a held word");

   // an action leaving the engine shows up as a valid result next cycle
   a_hit_lands: assert property (@(posedge clock) disable iff (reset)
      advance && eng_hit |=> rsp_valid)
      else $error("recognized action lost before the result register");

   // a tick only ever yields a single tap
   a_tick_single: assert property (@(posedge clock) disable iff (reset)
      advance && eng_hit && (in_type_ff == tgq_pkg::REQ_TICK)
         |-> eng_action == tgq_pkg::GEST_STAP)
      else $error("tick produced an action other than a single tap");

   // every result carries a real action code
   a_action_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_action == tgq_pkg::GEST_STAP) || (rsp_action == tgq_pkg::GEST_DTAP)
         || (rsp_action == tgq_pkg::GEST_SHAKE) || (rsp_action == tgq_pkg::GEST_SWIPE))
      else $error("result with an invalid action code");

endmodule

/* hdl/tgq_csr.sv */
// ---------------------------------------------------------------------------
// tgq_csr: configuration registers
// APB-style register file holding the five qualifier settings.
// ---------------------------------------------------------------------------
module tgq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tgq_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [tgq_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [tgq_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready,
   output tgq_pkg::cfg_type                    cfg
);

   tgq_pkg::cfg_type       cfg_ff;
   tgq_pkg::cfg_type       cfg_in;
   tgq_pkg::reg_index_type reg_idx;
   logic                   wr_en;

   assign reg_idx = tgq_pkg::reg_index_type'(paddr[tgq_pkg::CSR_ADDR_BITS-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            tgq_pkg::REG_RATE_LIMIT:  cfg_in.rate_limit  = pwdata[7:0];
            tgq_pkg::REG_DEBOUNCE_MS: cfg_in.debounce_ms = pwdata[15:0];
            tgq_pkg::REG_WINDOW_MS:   cfg_in.window_ms   = pwdata[15:0];
            tgq_pkg::REG_MIN_GAP_MS:  cfg_in.min_gap_ms  = pwdata[15:0];
            tgq_pkg::REG_NEUTRAL_DIR: cfg_in.neutral_dir = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         tgq_pkg::REG_RATE_LIMIT:  prdata = 32'(cfg_ff.rate_limit);
         tgq_pkg::REG_DEBOUNCE_MS: prdata = 32'(cfg_ff.debounce_ms);
         tgq_pkg::REG_WINDOW_MS:   prdata = 32'(cfg_ff.window_ms);
         tgq_pkg::REG_MIN_GAP_MS:  prdata = 32'(cfg_ff.min_gap_ms);
         tgq_pkg::REG_NEUTRAL_DIR: prdata = 32'(cfg_ff.neutral_dir);
         default:                  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_limit  <= tgq_pkg::RATE_LIMIT_RESET;
         cfg_ff.debounce_ms <= tgq_pkg::DEBOUNCE_RESET;
         cfg_ff.window_ms   <= tgq_pkg::WINDOW_RESET;
         cfg_ff.min_gap_ms  <= tgq_pkg::MIN_GAP_RESET;
         cfg_ff.neutral_dir <= tgq_pkg::NEUTRAL_DIR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/tgq_engine.sv */
// ---------------------------------------------------------------------------
// tgq_engine: qualifier state and decision logic
// Holds the rate counter, debounce stamp and pending tap; decides one word.
// ---------------------------------------------------------------------------
module tgq_engine #(
   parameter int TIME_BITS = tgq_pkg::DEF_TIME_BITS,
   parameter int DIR_BITS  = tgq_pkg::DEF_DIR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  tgq_pkg::cfg_type      cfg,
   input  logic                  in_type,
   input  logic [TIME_BITS-1:0]  in_now,
   input  logic [2:0]            in_gesture,
   input  logic [DIR_BITS-1:0]   in_dir,
   output logic                  out_hit,
   output logic [2:0]            out_action,
   output logic [DIR_BITS-1:0]   out_dir
);

   logic [7:0]           event_count_ff, event_count_in;
   logic [TIME_BITS-1:0] last_action_time_ff, last_action_time_in;
   logic [1:0]           tap_count_ff, tap_count_in;
   logic [TIME_BITS-1:0] tap_time_ff, tap_time_in;
   logic [DIR_BITS-1:0]  tap_dir_ff, tap_dir_in;

   logic [TIME_BITS-1:0] dt_tap, dt_action;
   logic [TIME_BITS-1:0] window_w, debounce_w, min_gap_w;
   logic [DIR_BITS-1:0]  neutral_w;
   logic [7:0]           cnt_inc, cnt_dec;
   logic                 tap_pending, tap_single, window_over;
   logic                 event_pass, dtap_ok;

   assign window_w   = TIME_BITS'(cfg.window_ms);
   assign debounce_w = TIME_BITS'(cfg.debounce_ms);
   assign min_gap_w  = TIME_BITS'(cfg.min_gap_ms);
   assign neutral_w  = DIR_BITS'(cfg.neutral_dir);

   // elapsed times wrap with the clock width
   assign dt_tap    = in_now - tap_time_ff;
   assign dt_action = in_now - last_action_time_ff;

   assign cnt_inc = (event_count_ff != tgq_pkg::EVENT_COUNT_MAX) ? event_count_ff + 8'd1
                                                                 : event_count_ff;
   assign cnt_dec = (event_count_ff != 8'd0) ? event_count_ff - 8'd1 : event_count_ff;

   assign tap_pending = (tap_time_ff != '0);
   assign tap_single  = tap_pending && (tap_count_ff == tgq_pkg::TAP_COUNT_ONE);
   assign window_over = (dt_tap > window_w);
   assign event_pass  = (cnt_inc <= cfg.rate_limit) && (dt_action >= debounce_w);
   assign dtap_ok     = tap_single && (dt_tap > min_gap_w) && (dt_tap < window_w);

   always_comb begin
      event_count_in      = event_count_ff;
      last_action_time_in = last_action_time_ff;
      tap_count_in        = tap_count_ff;
      tap_time_in         = tap_time_ff;
      tap_dir_in          = tap_dir_ff;
      out_hit             = 1'b0;
      out_action          = tgq_pkg::GEST_NONE;
      out_dir             = in_dir;
      if (in_type == tgq_pkg::REQ_TICK) begin
         event_count_in = cnt_dec;
         if (tap_single && window_over) begin
            // lone tap timed out: report it as a single tap
            out_hit             = 1'b1;
            out_action          = tgq_pkg::GEST_STAP;
            out_dir             = tap_dir_ff;
            last_action_time_in = in_now;
            tap_count_in        = 2'd0;
            tap_time_in         = '0;
            tap_dir_in          = neutral_w;
         end else if ((tap_pending || (tap_count_ff != 2'd0)) && window_over) begin
            tap_count_in = 2'd0;
            tap_time_in  = '0;
            tap_dir_in   = neutral_w;
         end
      end else begin
         event_count_in = cnt_inc;
         if (event_pass) begin
            unique case (in_gesture)
               tgq_pkg::GEST_STAP: begin
                  if (dtap_ok) begin
                     out_hit             = 1'b1;
                     out_action          = tgq_pkg::GEST_DTAP;
                     out_dir             = in_dir & tap_dir_ff;
                     last_action_time_in = in_now;
                     tap_count_in        = 2'd0;
                     tap_time_in         = '0;
                     tap_dir_in          = neutral_w;
                  end else begin
                     if (tap_count_ff != tgq_pkg::TAP_COUNT_MAX) begin
                        tap_count_in = tap_count_ff + 2'd1;
                     end
                     tap_time_in = in_now;
                     tap_dir_in  = in_dir;
                  end
               end
               tgq_pkg::GEST_DTAP, tgq_pkg::GEST_SHAKE, tgq_pkg::GEST_SWIPE: begin
                  out_hit             = 1'b1;
                  out_action          = in_gesture;
                  last_action_time_in = in_now;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         event_count_ff      <= '0;
         last_action_time_ff <= '0;
         tap_count_ff        <= '0;
         tap_time_ff         <= '0;
         tap_dir_ff          <= DIR_BITS'(tgq_pkg::NEUTRAL_DIR_RESET);
      end else if (step) begin
         event_count_ff      <= event_count_in;
         last_action_time_ff <= last_action_time_in;
         tap_count_ff        <= tap_count_in;
         tap_time_ff         <= tap_time_in;
         tap_dir_ff          <= tap_dir_in;
      end
   end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the tap gesture qualifier unit
// Walks a directed table (reset values, timing boundaries, every gesture,
// unused codes, tap at time zero), then random event/tick streams under
// several register settings. A shadow model predicts each action. The
// request side runs in bursts and the response side stalls on its own.
// ---------------------------------------------------------------------------
module tb_top;

   localparam int TB_TIME_BITS = tgq_pkg::DEF_TIME_BITS;
   localparam int TB_DIR_BITS  = tgq_pkg::DEF_DIR_BITS;
   localparam int SETTLE_CYCLES = 8;     // pipeline is two deep; leave headroom
   localparam int DRAIN_LIMIT   = 5000;
   localparam int WORDS_PER_PHASE = 180;
   localparam int PHASE_COUNT     = 8;
   localparam logic [2:0] GEST_UNUSED_TOP = 3'd7;

   typedef struct packed {
      logic                    kind;
      logic [TB_TIME_BITS-1:0] now_ms;
      logic [2:0]              gesture;
      logic [TB_DIR_BITS-1:0]  dir_mask;
   } word_rec_type;

   typedef struct packed {
      logic                    hit;
      logic [2:0]              action;
      logic [TB_DIR_BITS-1:0]  dir;
      logic [TB_TIME_BITS-1:0] stamp;
   } action_rec_type;

   // directed row: when typed is set, the expected action is written out
   typedef struct packed {
      word_rec_type   w;
      logic           typed;
      action_rec_type act;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid    = 1'b0;
   logic                    req_stall;
   logic                    req_type     = tgq_pkg::REQ_EVENT;
   logic [TB_TIME_BITS-1:0] req_now_ms   = '0;
   logic [2:0]              req_gesture  = tgq_pkg::GEST_NONE;
   logic [TB_DIR_BITS-1:0]  req_dir_mask = '0;

   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [2:0]              rsp_action;
   logic [TB_DIR_BITS-1:0]  rsp_action_dir;
   logic [TB_TIME_BITS-1:0] rsp_action_time;

   logic                              psel    = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite  = 1'b0;
   logic [tgq_pkg::CSR_ADDR_BITS-1:0] paddr   = '0;
   logic [tgq_pkg::CSR_DATA_BITS-1:0] pwdata  = '0;
   logic [tgq_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                              pready;

   tap_gesture_qualifier_unit #(
      .TIME_BITS(TB_TIME_BITS),
      .DIR_BITS (TB_DIR_BITS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_now_ms     (req_now_ms),
      .req_gesture    (req_gesture),
      .req_dir_mask   (req_dir_mask),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_action_dir (rsp_action_dir),
      .rsp_action_time(rsp_action_time),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // shadow copy of the registers and the qualifier state
   tgq_pkg::cfg_type        cfg_shadow;
   logic [7:0]              ev_count;
   logic [TB_TIME_BITS-1:0] last_act_ms;
   logic [1:0]              tap_cnt;
   logic [TB_TIME_BITS-1:0] tap_ms;
   logic [TB_DIR_BITS-1:0]  tap_mask;

   action_rec_type          pending_actions[$];
   stim_row_type            directed_q[$];
   logic [TB_TIME_BITS-1:0] wall_ms;
   int                      errors = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   // Fail the run if it hangs; sized far above the slowest legal run.
   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Shadow model
   // ------------------------------------------------------------------
   function automatic void clear_taps();
      tap_cnt  = '0;
      tap_ms   = '0;
      tap_mask = cfg_shadow.neutral_dir;
   endfunction

   function automatic action_rec_type action_of(logic [2:0] act,
                                                logic [TB_DIR_BITS-1:0] dir,
                                                logic [TB_TIME_BITS-1:0] stamp);
      action_rec_type r;
      r.hit    = 1'b1;
      r.action = act;
      r.dir    = dir;
      r.stamp  = stamp;
      return r;
   endfunction

   // Advance the shadow state by one word and return the action it yields.
   function automatic action_rec_type qualify_word(word_rec_type w);
      action_rec_type          r;
      logic [TB_TIME_BITS-1:0] since_tap;
      logic [TB_TIME_BITS-1:0] since_act;
      r = '0;
      since_tap = w.now_ms - tap_ms;
      if (w.kind == tgq_pkg::REQ_TICK) begin
         // drain the rate counter, then retire a lone tap or stale tap state
         if (ev_count != 0) ev_count = ev_count - 1'b1;
         if (tap_ms != 0 && tap_cnt == tgq_pkg::TAP_COUNT_ONE &&
             since_tap > cfg_shadow.window_ms) begin
            r = action_of(tgq_pkg::GEST_STAP, tap_mask, w.now_ms);
            clear_taps();
         end else if ((tap_ms != 0 || tap_cnt != 0) && since_tap > cfg_shadow.window_ms) begin
            clear_taps();
         end
      end else begin
         if (ev_count != tgq_pkg::EVENT_COUNT_MAX) ev_count = ev_count + 1'b1;
         since_act = w.now_ms - last_act_ms;
         if (ev_count <= cfg_shadow.rate_limit && since_act >= cfg_shadow.debounce_ms) begin
            case (w.gesture)
               tgq_pkg::GEST_STAP: begin
                  if (tap_ms != 0 && tap_cnt == tgq_pkg::TAP_COUNT_ONE &&
                      since_tap > cfg_shadow.min_gap_ms && since_tap < cfg_shadow.window_ms) begin
                     r = action_of(tgq_pkg::GEST_DTAP, w.dir_mask & tap_mask, w.now_ms);
                     clear_taps();
                  end else begin
                     if (tap_cnt != tgq_pkg::TAP_COUNT_MAX) tap_cnt = tap_cnt + 1'b1;
                     tap_mask = w.dir_mask;
                     tap_ms   = w.now_ms;
                  end
               end
               tgq_pkg::GEST_DTAP, tgq_pkg::GEST_SHAKE, tgq_pkg::GEST_SWIPE: begin
                  r = action_of(w.gesture, w.dir_mask, w.now_ms);
               end
               default: begin
               end
            endcase
         end
      end
      if (r.hit) last_act_ms = r.stamp;
      return r;
   endfunction

   function automatic stim_row_type row(logic kind, logic [TB_TIME_BITS-1:0] now_ms,
                                        logic [2:0] gest, logic [TB_DIR_BITS-1:0] dir,
                                        logic typed, logic fires, logic [2:0] act,
                                        logic [TB_DIR_BITS-1:0] adir);
      stim_row_type s;
      s.w.kind     = kind;
      s.w.now_ms   = now_ms;
      s.w.gesture  = gest;
      s.w.dir_mask = dir;
      s.typed      = typed;
      s.act        = fires ? action_of(act, adir, now_ms) : '0;
      return s;
   endfunction

   // Walk time forward mostly in small steps, with rare jumps and resets to zero.
   function automatic word_rec_type random_word();
      word_rec_type w;
      int           pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      wall_ms = wall_ms + $urandom_range(0, 60);
      else if (pick < 65) wall_ms = wall_ms + $urandom_range(0, 700);
      else if (pick < 85) wall_ms = wall_ms + $urandom_range(0, 3000);
      else if (pick < 95) wall_ms = wall_ms + $urandom_range(0, 70000);
      else if (pick < 98) wall_ms = $urandom;
      else                wall_ms = '0;
      w.now_ms = wall_ms;
      w.kind   = ($urandom_range(0, 99) < 40) ? tgq_pkg::REQ_TICK : tgq_pkg::REQ_EVENT;
      pick = $urandom_range(0, 99);
      if (pick < 55)      w.gesture = tgq_pkg::GEST_STAP;
      else if (pick < 65) w.gesture = tgq_pkg::GEST_DTAP;
      else if (pick < 75) w.gesture = tgq_pkg::GEST_SHAKE;
      else if (pick < 85) w.gesture = tgq_pkg::GEST_SWIPE;
      else if (pick < 92) w.gesture = tgq_pkg::GEST_NONE;
      else                w.gesture = 3'($urandom_range(5, 7));
      w.dir_mask = TB_DIR_BITS'($urandom);
      return w;
   endfunction

   // ------------------------------------------------------------------
   // Bus tasks
   // ------------------------------------------------------------------
   task automatic csr_write(tgq_pkg::reg_index_type idx,
                            logic [tgq_pkg::CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         tgq_pkg::REG_RATE_LIMIT:  cfg_shadow.rate_limit  = value[7:0];
         tgq_pkg::REG_DEBOUNCE_MS: cfg_shadow.debounce_ms = value[15:0];
         tgq_pkg::REG_WINDOW_MS:   cfg_shadow.window_ms   = value[15:0];
         tgq_pkg::REG_MIN_GAP_MS:  cfg_shadow.min_gap_ms  = value[15:0];
         tgq_pkg::REG_NEUTRAL_DIR: cfg_shadow.neutral_dir = value[7:0];
         default: begin
         end
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic load_settings(tgq_pkg::cfg_type c);
      csr_write(tgq_pkg::REG_RATE_LIMIT,  32'(c.rate_limit));
      csr_write(tgq_pkg::REG_DEBOUNCE_MS, 32'(c.debounce_ms));
      csr_write(tgq_pkg::REG_WINDOW_MS,   32'(c.window_ms));
      csr_write(tgq_pkg::REG_MIN_GAP_MS,  32'(c.min_gap_ms));
      csr_write(tgq_pkg::REG_NEUTRAL_DIR, 32'(c.neutral_dir));
   endtask

   // Present one word and hold it until the unit takes it. Valid stays high
   // afterwards; idle_req drops it when a gap is wanted.
   task automatic drive_word(word_rec_type w);
      @(negedge clock);
      req_valid    <= 1'b1;
      req_type     <= w.kind;
      req_now_ms   <= w.now_ms;
      req_gesture  <= w.gesture;
      req_dir_mask <= w.dir_mask;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_req(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Wait for every expected action, then let words with no action drain.
   task automatic settle();
      int waited;
      waited = 0;
      idle_req(1);
      while (pending_actions.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_actions.size() != 0) begin
         $error("drain: %0d actions never arrived", pending_actions.size());
         errors++;
         pending_actions.delete();
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: stall pattern and checker
   // ------------------------------------------------------------------
   initial begin
      int   mode;
      int   left;
      int   run;
      logic hold;
      mode = 0;
      left = 0;
      run  = 0;
      hold = 1'b0;
      forever begin
         @(negedge clock);
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 150);
         end
         left--;
         case (mode)
            0: hold = 1'b0;
            1: hold = ($urandom_range(0, 3) == 0);
            2: hold = ($urandom_range(0, 3) != 0);
            default: hold = ~hold;
         endcase
         // cap the length of any stall run with the run counter
         if (run >= 8) hold = 1'b0;
         run = hold ? run + 1 : 0;
         rsp_stall <= hold;
      end
   end

   always @(posedge clock) begin
      action_rec_type exp_act;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_actions.size() == 0) begin
            $error("unexpected action %0d dir %0h time %0h",
                   rsp_action, rsp_action_dir, rsp_action_time);
            errors++;
         end else begin
            exp_act = pending_actions.pop_front();
            if (rsp_action !== exp_act.action) begin
               $error("action: expected %0d, got %0d", exp_act.action, rsp_action);
               errors++;
            end
            if (rsp_action_dir !== exp_act.dir) begin
               $error("action_dir: expected %0h, got %0h", exp_act.dir, rsp_action_dir);
               errors++;
            end
            if (rsp_action_time !== exp_act.stamp) begin
               $error("action_time: expected %0h, got %0h", exp_act.stamp, rsp_action_time);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      tgq_pkg::cfg_type c;
      word_rec_type     w;
      action_rec_type   r;
      stim_row_type     s;
      int               burst_left;

      cfg_shadow.rate_limit  = tgq_pkg::RATE_LIMIT_RESET;
      cfg_shadow.debounce_ms = tgq_pkg::DEBOUNCE_RESET;
      cfg_shadow.window_ms   = tgq_pkg::WINDOW_RESET;
      cfg_shadow.min_gap_ms  = tgq_pkg::MIN_GAP_RESET;
      cfg_shadow.neutral_dir = tgq_pkg::NEUTRAL_DIR_RESET;
      ev_count    = '0;
      last_act_ms = '0;
      clear_taps();
      burst_left = 0;

      // Defaults: rate 5, debounce 200, window 500, min gap 50, neutral 0.
      // Debounce: too early after reset, then right at the boundary.
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd100, tgq_pkg::GEST_SHAKE, 8'h11,
                               1, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_TICK,  32'd150, tgq_pkg::GEST_NONE, 8'h00,
                               1, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd1000, tgq_pkg::GEST_SHAKE, 8'hFF,
                               1, 1, tgq_pkg::GEST_SHAKE, 8'hFF));
      directed_q.push_back(row(tgq_pkg::REQ_TICK,  32'd1001, tgq_pkg::GEST_NONE, 8'h00,
                               1, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd1100, tgq_pkg::GEST_SWIPE, 8'h00,
                               1, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_TICK,  32'd1150, tgq_pkg::GEST_NONE, 8'h00,
                               1, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd1200, tgq_pkg::GEST_SWIPE, 8'hA5,
                               1, 1, tgq_pkg::GEST_SWIPE, 8'hA5));
      directed_q.push_back(row(tgq_pkg::REQ_TICK,  32'd1201, tgq_pkg::GEST_NONE, 8'h00,
                               1, 0, 0, 0));
      // top of the time range, then wrap to zero
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'hFFFF_FFFF, tgq_pkg::GEST_DTAP, 8'h5A,
                               1, 1, tgq_pkg::GEST_DTAP, 8'h5A));
      directed_q.push_back(row(tgq_pkg::REQ_TICK,  32'd0, tgq_pkg::GEST_NONE, 8'h00,
                               1, 0, 0, 0));
      // second tap exactly at the min gap: noted, not paired; tick clears it
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd300, tgq_pkg::GEST_STAP, 8'h0F,
                               1, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd350, tgq_pkg::GEST_STAP, 8'h3C,
                               1, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_TICK,  32'd851, tgq_pkg::GEST_NONE, 8'h00,
                               1, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_TICK,  32'd852, tgq_pkg::GEST_NONE, 8'h00,
                               1, 0, 0, 0));
      // a real double tap: directions are ANDed
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd1000, tgq_pkg::GEST_STAP, 8'hF0,
                               1, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd1051, tgq_pkg::GEST_STAP, 8'h3C,
                               1, 1, tgq_pkg::GEST_DTAP, 8'h30));
      // lone tap: held at the window edge, single tap one ms later
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd1300, tgq_pkg::GEST_STAP, 8'h81,
                               1, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_TICK,  32'd1800, tgq_pkg::GEST_NONE, 8'h00,
                               1, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_TICK,  32'd1801, tgq_pkg::GEST_NONE, 8'h00,
                               1, 1, tgq_pkg::GEST_STAP, 8'h81));
      // unused gesture codes: counted, no action
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd5000, tgq_pkg::GEST_NONE, 8'hFF,
                               1, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd5001, GEST_UNUSED_TOP, 8'hFF,
                               1, 0, 0, 0));
      // tap stamped at zero counts as none pending, then rate limit kicks in
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd0, tgq_pkg::GEST_STAP, 8'h42,
                               0, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd100, tgq_pkg::GEST_STAP, 8'h24,
                               0, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_EVENT, 32'd400, tgq_pkg::GEST_SHAKE, 8'h01,
                               0, 0, 0, 0));
      directed_q.push_back(row(tgq_pkg::REQ_TICK,  32'd700, tgq_pkg::GEST_NONE, 8'h00,
                               0, 0, 0, 0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: c = cfg_shadow;
            1: begin
               c.rate_limit  = 8'd255;
               c.debounce_ms = 16'd0;
               c.window_ms   = 16'hFFFF;
               c.min_gap_ms  = 16'd0;
               c.neutral_dir = 8'hFF;
            end
            2: begin
               c.rate_limit  = 8'd0;
               c.debounce_ms = 16'hFFFF;
               c.window_ms   = 16'd0;
               c.min_gap_ms  = 16'hFFFF;
               c.neutral_dir = 8'h00;
            end
            3: begin
               c.rate_limit  = 8'd1;
               c.debounce_ms = 16'd0;
               c.window_ms   = 16'hFFFF;
               c.min_gap_ms  = 16'hFFFF;
               c.neutral_dir = 8'h5A;
            end
            default: begin
               c.rate_limit  = 8'($urandom_range(1, 12));
               c.debounce_ms = 16'($urandom_range(0, 300));
               c.window_ms   = 16'($urandom_range(50, 1500));
               c.min_gap_ms  = 16'($urandom_range(0, 200));
               c.neutral_dir = 8'($urandom);
            end
         endcase
         if (phase != 0) begin
            settle();
            load_settings(c);
         end
         wall_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000
                                               : TB_TIME_BITS'($urandom_range(0, 5000));

         if (phase == 0) begin
            // walk the directed table back to back
            foreach (directed_q[i]) begin
               s = directed_q[i];
               drive_word(s.w);
               r = qualify_word(s.w);
               if (s.typed) r = s.act;
               if (r.hit) pending_actions.push_back(r);
            end
            idle_req(3);
         end

         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            // midway, hold off until the unit has delivered everything
            if (n == WORDS_PER_PHASE / 2) settle();
            w = random_word();
            drive_word(w);
            r = qualify_word(w);
            if (r.hit) pending_actions.push_back(r);
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 8);
               idle_req($urandom_range(1, 12));
            end
            burst_left--;
         end
      end

      settle();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
